// ===== sv/fftfi_pkg.sv =====
// Package for the FFT frequency index generator: widths, register codes and
// the per-dimension status struct. No dependencies.
`timescale 1ns / 1ps

package fftfi_pkg;

  localparam int MAX_DIMS  = 4;
  localparam int MAX_SIZE  = 256;
  localparam int DIGIT_W   = $clog2(MAX_SIZE);   // digit 0..MAX_SIZE-1
  localparam int SIZE_W    = DIGIT_W + 1;        // size 1..MAX_SIZE
  localparam int DCNT_W    = 3;                  // dim_count register width
  localparam int FREQ_W    = 8;
  localparam int POS_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 9;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = MAX_DIMS * FREQ_W + POS_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_SIZE_0    = 3'd1,
    CFG_SIZE_1    = 3'd2,
    CFG_SIZE_2    = 3'd3,
    CFG_SIZE_3    = 3'd4,
    CFG_NYQ_MODE  = 3'd5
  } cfg_reg_t;

  // status of one dimension for the carry chain and flags
  typedef struct packed {
    logic wrap;   // digit at its maximum, next carry wraps it
    logic nyq;    // digit equals floor(N/2)
  } dim_stat_t;

endpackage

// ===== sv/fft_frequency_index_generator_unit.sv =====
// Top level of the FFT frequency index generator: config registers, digit
// state, carry chain and output register. Depends on fftfi_pkg, fftfi_dim.
`timescale 1ns / 1ps

// Channel | Direction | Handshake        | Payload
// in_     | slave     | tvalid / tready  | tdata[0] restart
// out_    | master    | tvalid / tready  | tdata freq_0..3, linear_index; tuser at_nyquist;
//         |           |                  | tlast last
// cfg_    | write     | cfg_wr_en        | cfg_index, cfg_wdata
//
// One word per cycle while the output is not stalled: each accepted word yields
// one result word in the next cycle. The path is digit registers -> per-dimension
// compare/subtract -> 4-deep carry chain -> output and digit registers.
// in_tready is high whenever the output register is empty or being drained,
// so a stalled output holds one result while the next word waits.
// Reset (rst_n low, synchronous) sets dim_count 1, all sizes 1, mode 0 and
// clears the walk to the origin.

module fft_frequency_index_generator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fftfi_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] restart, rest zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] freq_0, [15:8] freq_1, [23:16] freq_2, [31:24] freq_3, [63:32] linear_index
  output logic [fftfi_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                              out_tuser,  // [0] at_nyquist
  output logic                              out_tlast,  // last point of grid
  input  logic                              cfg_wr_en,
  input  logic [fftfi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fftfi_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import fftfi_pkg::*;

  // config registers
  logic [DCNT_W-1:0]   dim_count_r;
  logic [SIZE_W-1:0]   size_r [MAX_DIMS];
  logic                nyq_mode_r;

  // walk state
  logic [DIGIT_W-1:0]  digit_r   [MAX_DIMS];
  logic [DIGIT_W-1:0]  digit_nxt [MAX_DIMS];
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    pos_nxt;

  // output register
  logic                out_valid_r;
  logic [FREQ_W-1:0]   out_freq_r [MAX_DIMS];
  logic [POS_W-1:0]    out_index_r;
  logic                out_nyq_r;
  logic                out_last_r;

  // datapath
  logic                in_acc;
  logic                restart;
  logic [DCNT_W-1:0]   dims_eff;
  logic [SIZE_W-1:0]   size_eff  [MAX_DIMS];
  logic [DIGIT_W-1:0]  digit_cur [MAX_DIMS];
  logic [FREQ_W-1:0]   freq      [MAX_DIMS];
  dim_stat_t           stat      [MAX_DIMS];
  logic [MAX_DIMS-1:0] active;
  logic [MAX_DIMS-1:0] pass;
  logic [MAX_DIMS-1:0] carry;
  logic [MAX_DIMS-1:0] nyq_vec;
  logic                fin;
  logic [POS_W-1:0]    pos_cur;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];

  // effective dimension count: 0 counts as 1, saturate at MAX_DIMS
  always_comb begin
    if (dim_count_r == '0) begin
      dims_eff = DCNT_W'(1);
    end else if (dim_count_r > DCNT_W'(MAX_DIMS)) begin
      dims_eff = DCNT_W'(MAX_DIMS);
    end else begin
      dims_eff = dim_count_r;
    end
  end

  // restart clears the walk before this point is produced
  assign pos_cur = restart ? '0 : pos_r;

  for (genvar j = 0; j < MAX_DIMS; j++) begin : g_dim
    always_comb begin
      if (size_r[j] == '0) begin
        size_eff[j] = SIZE_W'(1);
      end else if (size_r[j] > SIZE_W'(MAX_SIZE)) begin
        size_eff[j] = SIZE_W'(MAX_SIZE);
      end else begin
        size_eff[j] = size_r[j];
      end
    end

    assign active[j]    = DCNT_W'(j) < dims_eff;
    assign digit_cur[j] = restart ? '0 : digit_r[j];
    // inactive dims pass the carry and never block the last flag
    assign pass[j]      = !active[j] || stat[j].wrap;
    assign nyq_vec[j]   = stat[j].nyq;

    if (j == MAX_DIMS - 1) begin : g_top
      assign carry[j] = 1'b1;
    end else begin : g_chain
      assign carry[j] = carry[j+1] && pass[j+1];
    end

    fftfi_dim u_dim (
      .active    (active[j]),
      .size_eff  (size_eff[j]),
      .digit     (digit_cur[j]),
      .nyq_mode  (nyq_mode_r),
      .carry_in  (carry[j]),
      .freq      (freq[j]),
      .stat      (stat[j]),
      .digit_nxt (digit_nxt[j])
    );
  end

  // on the final point every active digit wraps, so digits return to zero
  assign fin     = &pass;
  assign pos_nxt = fin ? '0 : pos_cur + POS_W'(1);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r <= DCNT_W'(1);
      for (int j = 0; j < MAX_DIMS; j++) begin
        size_r[j] <= SIZE_W'(1);
      end
      nyq_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DIM_COUNT: dim_count_r <= cfg_wdata[DCNT_W-1:0];
        CFG_SIZE_0:    size_r[0]   <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_1:    size_r[1]   <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_2:    size_r[2]   <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE_3:    size_r[3]   <= cfg_wdata[SIZE_W-1:0];
        CFG_NYQ_MODE:  nyq_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        digit_r[j] <= '0;
      end
      pos_r <= '0;
    end else if (in_acc) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        digit_r[j] <= digit_nxt[j];
      end
      pos_r <= pos_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        out_freq_r[j] <= freq[j];
      end
      out_index_r <= pos_cur;
      out_nyq_r   <= |nyq_vec;
      out_last_r  <= fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_freq_r[3], out_freq_r[2],
                       out_freq_r[1], out_freq_r[0]};
  assign out_tuser  = out_nyq_r;
  assign out_tlast  = out_last_r;

  // the last point of a walk leaves the state at the origin
  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fin |=> pos_r == '0 && digit_r[0] == '0)
    else $error("walk not cleared after last point");

  // a restart word reports the origin
  a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && restart |=> out_index_r == '0)
    else $error("restart did not report origin");

  // an accepted word is always followed by a valid result
  a_acc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  // input back-pressure only while a result is held
  a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_valid_r && !out_tready)
    else $error("input stalled without a held result");

  // position advances by one between non-final, non-restart words
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !restart && !fin |=> pos_r == $past(pos_r) + POS_W'(1))
    else $error("position did not advance");

endmodule

// ===== sv/fftfi_dim.sv =====
// One dimension of the index walk: frequency mapping and next digit.
// Depends on fftfi_pkg.
`timescale 1ns / 1ps

module fftfi_dim (
  input  logic                          active,
  input  logic [fftfi_pkg::SIZE_W-1:0]  size_eff,
  input  logic [fftfi_pkg::DIGIT_W-1:0] digit,
  input  logic                          nyq_mode,
  input  logic                          carry_in,
  output logic [fftfi_pkg::FREQ_W-1:0]  freq,
  output fftfi_pkg::dim_stat_t          stat,
  output logic [fftfi_pkg::DIGIT_W-1:0] digit_nxt
);
  import fftfi_pkg::*;

  logic [DIGIT_W-1:0] k;
  logic [DIGIT_W-1:0] half;
  logic [DIGIT_W-1:0] n_m1;
  logic [DIGIT_W-1:0] k_minus_n;
  logic               gt;
  logic               eq;

  always_comb begin
    k         = active ? digit : '0;
    half      = size_eff[SIZE_W-1:1];
    n_m1      = DIGIT_W'(size_eff - SIZE_W'(1));
    k_minus_n = k - size_eff[DIGIT_W-1:0];   // mod 2^DIGIT_W
    gt        = k > half;
    eq        = k == half;

    stat.wrap = active && (k >= n_m1);
    stat.nyq  = active && eq;

    if (!active) begin
      freq = '0;
    end else if (gt || (eq && nyq_mode)) begin
      freq = FREQ_W'(k_minus_n);
    end else if (eq) begin
      freq = '0;
    end else begin
      freq = FREQ_W'(k);
    end

    if (!active) begin
      digit_nxt = '0;
    end else if (carry_in) begin
      digit_nxt = stat.wrap ? '0 : k + DIGIT_W'(1);
    end else begin
      digit_nxt = k;
    end
  end

endmodule
